// ----- sv/dds_waveform_generator_assert.svh -----
// Assertion macros used by the checker file of the waveform generator.
`ifndef DDS_WAVEFORM_GENERATOR_ASSERT_SVH
`define DDS_WAVEFORM_GENERATOR_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define DWG_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define DWG_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define DWG_ASSERT_NXT_ALL(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dwg_pkg.sv -----
package dwg_pkg;

  // Datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int STEP_BITS       = 32;
  localparam int AMP_BITS        = 16;
  localparam int AMP_FRAC        = 15;
  localparam int WAVE_BITS       = 3;
  localparam int LFSR_BITS       = 32;

  localparam int QUARTER_LEN = 2 ** SINE_TABLE_BITS;
  localparam int ROM_ADDR_W  = SINE_TABLE_BITS + 1;
  // raw wave spans -H .. +H, one bit more than a sample
  localparam int RAW_W       = SAMPLE_BITS + 1;
  localparam int PROD_W      = RAW_W + AMP_BITS + 1;

  localparam logic [LFSR_BITS-1:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [AMP_BITS-1:0]  AMP_RESET = 16'h8000;

  // half pi in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Wave select codes
  localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [WAVE_BITS-1:0] WAVE_NOISE    = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd2;
  localparam int CFG_DATA_W = 32;

  typedef logic [SAMPLE_BITS-1:0] sine_rom_t [0:QUARTER_LEN];

  // Raw wave beat handed from the wave stage to the gain stage
  typedef struct packed {
    logic                    valid;
    logic signed [RAW_W-1:0] raw;
  } raw_beat_t;

  // Quarter-wave magnitudes, Taylor series in Q30, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t           rom;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    logic signed [63:0]  v;
    logic signed [63:0]  h;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      h    = 64'sd1 <<< (SAMPLE_BITS - 1);
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
      if (sum < 0) sum = 0;
      v = (sum * h + (64'sd1 <<< 29)) >>> 30;
      if (v > h) v = h;
      rom[ROM_ADDR_W'(i)] = SAMPLE_BITS'(v);
    end
    return rom;
  endfunction

endpackage

// ----- sv/dwg_wave.sv -----
module dwg_wave (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick,       // tick beat offered, sample_tick set
  input  logic                               tick_valid, // beat offered at all
  output logic                               tick_ready,
  input  logic [dwg_pkg::WAVE_BITS-1:0]      wave_type,
  input  logic [dwg_pkg::STEP_BITS-1:0]      phase_step,
  output dwg_pkg::raw_beat_t                 raw_out,
  input  logic                               raw_ready
);
  import dwg_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [RAW_W-1:0] HALF   = RAW_W'(2 ** (SAMPLE_BITS - 1));
  localparam logic [RAW_W-1:0] THREE_H = RAW_W'(3 * (2 ** (SAMPLE_BITS - 1)));

  logic [SAMPLE_BITS-1:0] sine_rom [0:QUARTER_LEN];

  logic [PHASE_BITS-1:0]  phase_acc;
  logic [LFSR_BITS-1:0]   noise_lfsr;
  logic [LFSR_BITS-1:0]   lfsr_next;
  logic                   take;
  logic                   en1;
  logic                   en2;
  logic [1:0]             quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ROM_ADDR_W-1:0]  rom_addr;

  // stage 1: table read and captured phase
  logic                   v1;
  logic [SAMPLE_BITS-1:0] rom_q;
  logic                   neg1;
  logic [WAVE_BITS-1:0]   wave1;
  logic [RAW_W-1:0]       u1;
  logic [SAMPLE_BITS-1:0] noise1;

  // stage 2: raw wave
  logic                   v2;
  logic signed [RAW_W-1:0] raw2;
  logic [RAW_W-1:0]       raw_next;

  assign sine_rom = SINE_ROM;

  // Bubble-collapsing advance enables
  assign en2        = !v2 || raw_ready;
  assign en1        = !v1 || en2;
  assign tick_ready = en1;
  assign take       = tick_valid && tick && en1;

  assign lfsr_next = (noise_lfsr >> 1) ^ ({LFSR_BITS{noise_lfsr[0]}} & LFSR_MASK);

  // Mirror the index in odd quadrants
  assign quad     = phase_acc[PHASE_BITS-1 -: 2];
  assign idx      = phase_acc[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (ROM_ADDR_W'(QUARTER_LEN) - {1'b0, idx}) : {1'b0, idx};

  // Advance phase on each taken tick, and noise state too when noise is selected
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      noise_lfsr <= LFSR_SEED;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (take) begin
        phase_acc <= phase_acc + PHASE_BITS'(phase_step);
        if (wave_type == WAVE_NOISE) noise_lfsr <= lfsr_next;
      end
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
    end
  end

  // Read the table and capture the other wave inputs
  always_ff @(posedge clk) begin
    if (en1) begin
      rom_q  <= sine_rom[rom_addr];
      neg1   <= quad[1];
      wave1  <= wave_type;
      u1     <= phase_acc[PHASE_BITS-1 -: RAW_W];
      noise1 <= lfsr_next[LFSR_BITS-1 -: SAMPLE_BITS];
    end
  end

  // Form the raw wave
  always_comb begin
    case (wave1)
      WAVE_SINE:     raw_next = neg1 ? (RAW_W'(0) - {1'b0, rom_q}) : {1'b0, rom_q};
      WAVE_SQUARE:   raw_next = u1[RAW_W-1] ? (RAW_W'(0) - HALF) : HALF;
      WAVE_TRIANGLE: raw_next = u1[RAW_W-1] ? (THREE_H - u1) : (u1 - HALF);
      WAVE_SAWTOOTH: raw_next = {1'b0, u1[RAW_W-1:1]} - HALF;
      WAVE_NOISE:    raw_next = {noise1[SAMPLE_BITS-1], noise1};
      default:       raw_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) raw2 <= $signed(raw_next);
  end

  assign raw_out.valid = v2;
  assign raw_out.raw   = raw2;

endmodule

// ----- sv/dwg_scale.sv -----
module dwg_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  dwg_pkg::raw_beat_t                 raw_in,
  output logic                               raw_ready,
  input  logic [dwg_pkg::AMP_BITS-1:0]       amplitude,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dwg_pkg::SAMPLE_BITS-1:0]    out_sample
);
  import dwg_pkg::*;

  localparam int Q_W = PROD_W - AMP_FRAC;
  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(2 ** (AMP_FRAC - 1));
  localparam logic signed [Q_W-1:0]    Q_MAX = Q_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [Q_W-1:0]    Q_MIN = ~Q_MAX;

  logic                     v3;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [Q_W-1:0]    q;
  logic signed [Q_W-1:0]    sat;
  logic                     en3;
  logic                     en4;

  assign en4       = !out_valid || out_ready;
  assign en3       = !v3 || en4;
  assign raw_ready = en3;

  // Apply gain
  always_ff @(posedge clk) begin
    if (en3) prod <= PROD_W'(raw_in.raw) * PROD_W'($signed({1'b0, amplitude}));
  end

  // Round half up, then clamp to the sample range
  assign rnd = prod + ROUND;
  assign q   = rnd[PROD_W-1:AMP_FRAC];

  always_comb begin
    if (q > Q_MAX)      sat = Q_MAX;
    else if (q < Q_MIN) sat = Q_MIN;
    else                sat = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) v3 <= raw_in.valid;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) out_sample <= sat[SAMPLE_BITS-1:0];
  end

endmodule

// ----- sv/dds_waveform_generator.sv -----
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------
// s_*       | in  | s_tdata[0] sample_tick, bits 7:1 zero
// m_*       | out | m_tdata[15:0] sample, signed Q1.15
// cfg_*     | in  | cfg_index register, cfg_data value (always ready)
//
// One sample per clock sustained while m_tready stays high; four pipe stages from tick to m_tvalid:
// sine table read, raw wave, gain multiply, round/clamp output register.
// The registered quarter-wave ROM read and the single gain multiplier set the pipe depth.
// Reset (rst, synchronous) loads wave sine, step zero, gain 1.0, phase zero, noise seed.
// Each stage holds only when the stage after it is full and stalled, so
// s_tready drops only when all four stages are full and m_tready is low.
// A beat with sample_tick clear is taken and yields nothing.
module dds_waveform_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] sample_tick
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [15:0] sample
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dwg_pkg::*;

  logic [WAVE_BITS-1:0] wave_type;
  logic [STEP_BITS-1:0] phase_step;
  logic [AMP_BITS-1:0]  amplitude;
  raw_beat_t            raw_beat;
  logic                 raw_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type  <= WAVE_SINE;
      phase_step <= '0;
      amplitude  <= AMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WAVE_TYPE:  wave_type  <= cfg_data[WAVE_BITS-1:0];
        CFG_PHASE_STEP: phase_step <= cfg_data[STEP_BITS-1:0];
        CFG_AMPLITUDE:  amplitude  <= cfg_data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  dwg_wave u_wave (
    .clk        (clk),
    .rst        (rst),
    .tick       (s_tdata[0]),
    .tick_valid (s_tvalid),
    .tick_ready (s_tready),
    .wave_type  (wave_type),
    .phase_step (phase_step),
    .raw_out    (raw_beat),
    .raw_ready  (raw_ready)
  );

  dwg_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .raw_in     (raw_beat),
    .raw_ready  (raw_ready),
    .amplitude  (amplitude),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata)
  );

endmodule

// ----- sv/dwg_checker.sv -----
`include "dds_waveform_generator_assert.svh"

module dwg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Reset empties the output register
  `DWG_ASSERT_NXT_ALL(a_reset_empties_out, clk, rst, !m_tvalid, "output valid after reset")

  // Input backs up only when every stage is full behind a stalled output
  `DWG_ASSERT_IMP(a_ready_only_on_backpressure, clk, rst, s_tvalid && !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

  // A stalled result beat holds
  `DWG_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output beat changed")

endmodule

bind dds_waveform_generator dwg_checker u_dwg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dwg_pkg::*;

  localparam int PIPE_LATENCY    = 4;
  localparam int SETTLE_CYCLES   = 2 * PIPE_LATENCY;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int MAX_WAIT        = 8;
  localparam int RANDOM_SETTINGS = 16;
  localparam longint TIMEOUT_NS  = 3_000_000;

  // Codes the block must treat as silence, and an index it must ignore
  localparam logic [WAVE_BITS-1:0] WAVE_SPARE_5 = 3'd5;
  localparam logic [WAVE_BITS-1:0] WAVE_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata   = '0;   // [0] sample_tick, [7:1] zero
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [15:0]             m_tdata;          // [15:0] sample
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // Predictor copy of the registers and state
  logic [WAVE_BITS-1:0]    wave_sel  = WAVE_SINE;
  logic [STEP_BITS-1:0]    step_size = '0;
  logic [AMP_BITS-1:0]     gain      = AMP_RESET;
  logic [PHASE_BITS-1:0]   phase_now = '0;
  logic [LFSR_BITS-1:0]    lfsr_now  = LFSR_SEED;
  longint                  sine_mag [0:QUARTER_LEN];

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];

  int  error_count     = 0;
  int  samples_checked = 0;
  int  ticks_sent      = 0;
  int  idle_beats      = 0;
  int  writes_done     = 0;
  bit  tx_idle_on      = 1'b1;
  bit  rx_idle_on      = 1'b1;
  bit  sample_taken    = 1'b0;
  int  rx_wait_left    = 0;

  dds_waveform_generator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build the quarter-wave magnitudes with a Q30 Taylor series
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    longint          h;
    h = longint'(1) << (SAMPLE_BITS - 1);
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      v = (sum * h + (longint'(1) << 29)) >>> 30;
      if (v > h) v = h;
      sine_mag[ROM_ADDR_W'(i)] = v;
    end
  end

  // Step noise state if noise is selected, produce the sample for the current phase, then advance phase
  function automatic logic signed [SAMPLE_BITS-1:0] predict_sample();
    longint                     h;
    longint                     u;
    longint                     raw;
    longint                     mag;
    longint                     scaled;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ROM_ADDR_W-1:0]      addr;
    h    = longint'(1) << (SAMPLE_BITS - 1);
    u    = longint'(phase_now >> (PHASE_BITS - SAMPLE_BITS - 1));
    quad = phase_now[PHASE_BITS-1 -: 2];
    idx  = phase_now[PHASE_BITS-3 -: SINE_TABLE_BITS];
    addr = quad[0] ? (ROM_ADDR_W'(QUARTER_LEN) - {1'b0, idx}) : {1'b0, idx};
    case (wave_sel)
      WAVE_SINE: begin
        mag = sine_mag[addr];
        raw = quad[1] ? -mag : mag;
      end
      WAVE_SQUARE:   raw = (u < 2 * h) ? h : -h;
      WAVE_TRIANGLE: raw = (u < 2 * h) ? (u - h) : (3 * h - u);
      WAVE_SAWTOOTH: raw = (u >>> 1) - h;
      WAVE_NOISE: begin
        lfsr_now = (lfsr_now >> 1) ^ (lfsr_now[0] ? LFSR_MASK : '0);
        raw      = $signed(lfsr_now[LFSR_BITS-1 -: SAMPLE_BITS]);
      end
      default:       raw = 0;
    endcase
    // round half up, floor toward minus infinity, then clamp
    scaled = (raw * longint'(gain) + (longint'(1) << (AMP_FRAC - 1))) >>> AMP_FRAC;
    if (scaled > h - 1) scaled = h - 1;
    if (scaled < -h) scaled = -h;
    phase_now = phase_now + step_size;
    return scaled[SAMPLE_BITS-1:0];
  endfunction

  // Check each output beat against the oldest expected sample
  always @(negedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    sample_taken = !rst && m_tvalid && m_tready;
    if (sample_taken) begin
      if (expected_samples.size() == 0) begin
        $error("sample: nothing expected, actual %0d", $signed(m_tdata));
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (m_tdata !== want) begin
          $error("sample: expected %0d, actual %0d", want, $signed(m_tdata));
          error_count++;
        end
        samples_checked++;
      end
    end
  end

  // Stall the output side for a random number of cycles after each beat while receive idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b1;
      rx_wait_left = 0;
    end else if (sample_taken) begin
      rx_wait_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (rx_wait_left > 0) m_tready <= 1'b0;
    end else if (rx_wait_left > 0) begin
      rx_wait_left--;
      if (rx_wait_left == 0) m_tready <= 1'b1;
    end
  end

  // Send one beat, after a random gap when transmit idling is on; predict a tick's sample on acceptance
  task automatic send_beat(input bit tick);
    int   gap;
    logic ready_seen;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, tick};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    if (tick) begin
      expected_samples.push_back(predict_sample());
      ticks_sent++;
    end else begin
      idle_beats++;
    end
  endtask

  // Hold the input until every expected sample is out, then let the pipe empty
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && expected_samples.size() != 0; c++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    logic ready_seen;
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WAVE_TYPE:  wave_sel  = value[WAVE_BITS-1:0];
      CFG_PHASE_STEP: step_size = value[STEP_BITS-1:0];
      CFG_AMPLITUDE:  gain      = value[AMP_BITS-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Reset values: sine at phase zero with zero step, and a beat with tick low
  task automatic test_reset_state();
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
  endtask

  // Full-scale square at unity gain: top clamps to max, bottom reaches min
  task automatic test_full_scale();
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SQUARE));
    write_register(CFG_PHASE_STEP, 32'h8000_0000);
    write_register(CFG_AMPLITUDE, CFG_DATA_W'(AMP_RESET));
    send_beat(1'b1);
    send_beat(1'b1);
  endtask

  // Sine, triangle and sawtooth at quarter-turn steps, noise at maximum gain, spare codes silent
  task automatic test_each_wave();
    write_register(CFG_PHASE_STEP, 32'h4000_0000);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SINE));
    repeat (4) send_beat(1'b1);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_TRIANGLE));
    repeat (2) send_beat(1'b1);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SAWTOOTH));
    repeat (2) send_beat(1'b1);
    write_register(CFG_AMPLITUDE, 32'h0000_FFFF);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_NOISE));
    repeat (2) send_beat(1'b1);
    write_register(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SPARE_5));
    send_beat(1'b1);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SPARE_7));
    send_beat(1'b1);
  endtask

  // Zero, tiny and near-double gain; then a write to an unused index
  task automatic test_gain_and_index();
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SAWTOOTH));
    write_register(CFG_AMPLITUDE, 32'd0);
    send_beat(1'b1);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_TRIANGLE));
    write_register(CFG_AMPLITUDE, 32'd1);
    send_beat(1'b1);
    write_register(CFG_WAVE_TYPE, CFG_DATA_W'(WAVE_SQUARE));
    write_register(CFG_AMPLITUDE, 32'h0000_FFFF);
    send_beat(1'b1);
    write_register(CFG_SPARE, 32'hFFFF_FFFF);
    send_beat(1'b1);
  endtask

  // Random settings per run, random tick pattern, idling rotated across runs
  task automatic test_random_runs();
    int               wanted;
    int               sent;
    bit               tick;
    logic [31:0]      step_pick;
    logic [31:0]      amp_pick;
    for (int run = 0; run < RANDOM_SETTINGS; run++) begin
      case ($urandom_range(0, 5))
        0:       step_pick = 32'd0;
        1:       step_pick = 32'd1;
        2:       step_pick = 32'h8000_0000;
        3:       step_pick = 32'hFFFF_FFFF;
        4:       step_pick = $urandom_range(1, 1 << 24);
        default: step_pick = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       amp_pick = 32'd0;
        1:       amp_pick = 32'd32767;
        2:       amp_pick = 32'(AMP_RESET);
        3:       amp_pick = 32'h0000_FFFF;
        4:       amp_pick = $urandom_range(0, 32'(AMP_RESET));
        default: amp_pick = $urandom_range(0, 16'hFFFF);
      endcase
      write_register(CFG_WAVE_TYPE, $urandom_range(0, 7));
      write_register(CFG_PHASE_STEP, step_pick);
      write_register(CFG_AMPLITUDE, amp_pick);
      if ($urandom_range(0, 3) == 0) write_register(CFG_SPARE, $urandom());
      tx_idle_on = (run % 4 == 0) || (run % 4 == 3);
      rx_idle_on = (run % 4 == 0) || (run % 4 == 2);
      wanted = $urandom_range(26, 56);
      sent   = 0;
      while (sent < wanted) begin
        tick = ($urandom_range(0, 9) != 0);
        send_beat(tick);
        if (tick) sent++;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_full_scale();
    test_each_wave();
    test_gain_and_index();
    test_random_runs();
    drain_pipe();
    if (expected_samples.size() != 0) begin
      $error("sample: %0d expected samples never arrived", expected_samples.size());
      error_count += expected_samples.size();
    end
    $display("Checked %0d samples from %0d ticks plus %0d idle beats,",
             samples_checked, ticks_sent, idle_beats);
    $display("  across %0d register writes covering all wave codes and gain extremes.",
             writes_done);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dwg_pkg.sv
sv/dwg_wave.sv
sv/dwg_scale.sv
sv/dds_waveform_generator.sv
sv/dwg_checker.sv
test/testbench.sv
